FILE: design/gcsf_pkg.sv
// Shared types and fixed field widths for the greedy corner spacing filter.
`default_nettype none

package gcsf_pkg;

   localparam int CFG_W       = 7;
   localparam int RANGE_W     = 8;
   localparam int KEPT_CNT_W  = 7;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } gcsf_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic last_idx;
      logic out_free;
   } gcsf_status_type;

endpackage

`default_nettype wire

FILE: design/gcsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gcsf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/gcsf_ctrl.sv
// Sequencing state machine: take a corner, scan the point store, commit the result.
`default_nettype none

module gcsf_ctrl
   import gcsf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire gcsf_status_type status,
   output gcsf_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.need_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (status.last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         // The last read's data is compared here.
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_FINISH) && status.out_free;

endmodule

`default_nettype wire

FILE: design/gcsf_dp.sv
// Datapath: corner registers, point store, spacing compare and result register.
`default_nettype none

module gcsf_dp
   import gcsf_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_start_of_frame,
   input  wire logic [COORD_BITS-1:0] req_corner_x,
   input  wire logic [COORD_BITS-1:0] req_corner_y,
   input  wire logic [RANGE_W-1:0]    req_spacing_range,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_W-1:0]      csr_wr_data,
   input  wire gcsf_cmd_type          cmd,
   output gcsf_status_type            status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic [COORD_BITS-1:0]      rsp_kept_x,
   output logic [COORD_BITS-1:0]      rsp_kept_y,
   output logic [KEPT_CNT_W-1:0]      rsp_kept_count,
   output logic                       rsp_store_full
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic [CFG_W-1:0]      max_points_ff, max_points_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  cmp_vld_ff;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [RANGE_W-1:0]    range_ff;
   logic                  acc_ff;
   logic [COORD_BITS-1:0] kept_x_ff, kept_y_ff;
   logic [KEPT_CNT_W-1:0] kept_count_ff;
   logic                  full_ff;

   logic [CNT_W-1:0]        limit;
   logic                    room;
   logic                    take;
   logic [CNT_W-1:0]        count_next;
   logic [31:0]             count_ext;
   logic [2*COORD_BITS-1:0] rd_data;
   logic [COORD_BITS-1:0]   rd_x, rd_y, dx, dy;
   logic                    near;

   gcsf_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.commit && take),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({x_ff, y_ff}),
      .rd_en   (cmd.scan),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // A limit of zero, or any value above the store size, means the full store.
   always_comb begin
      if ((max_points_ff == '0) || (32'(max_points_ff) > MAX_POINTS)) begin
         limit = CNT_W'(MAX_POINTS);
      end else begin
         limit = CNT_W'(max_points_ff);
      end
   end

   assign room       = (count_ff < limit);
   assign take       = room && !hit_ff;
   assign count_next = count_ff + CNT_W'(take);
   assign count_ext  = 32'(count_next);

   assign rd_x = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rd_y = rd_data[COORD_BITS-1:0];
   assign dx   = (rd_x > x_ff) ? (rd_x - x_ff) : (x_ff - rd_x);
   assign dy   = (rd_y > y_ff) ? (rd_y - y_ff) : (y_ff - rd_y);
   assign near = (32'(dx) < 32'(range_ff)) && (32'(dy) < 32'(range_ff));

   always_comb begin
      max_points_in = csr_wr_en ? csr_wr_data : max_points_ff;

      count_in = count_ff;
      if (cmd.load && req_start_of_frame) begin
         count_in = '0;
      end else if (cmd.commit) begin
         count_in = count_next;
      end

      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      hit_in = hit_ff;
      if (cmd.load) begin
         hit_in = 1'b0;
      end else if (cmp_vld_ff && near) begin
         hit_in = 1'b1;
      end

      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_points_ff <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_points_ff <= max_points_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         cmp_vld_ff    <= cmd.scan;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= req_corner_x;
         y_ff     <= req_corner_y;
         range_ff <= req_spacing_range;
      end
      if (cmd.commit) begin
         acc_ff        <= take;
         kept_x_ff     <= x_ff;
         kept_y_ff     <= y_ff;
         kept_count_ff <= count_ext[KEPT_CNT_W-1:0];
         full_ff       <= (count_next >= limit);
      end
   end

   assign status.need_scan = room && (count_ff != '0);
   assign status.last_idx  = ((idx_ff + CNT_W'(1)) == count_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_kept_x     = kept_x_ff;
   assign rsp_kept_y     = kept_y_ff;
   assign rsp_kept_count = kept_count_ff;
   assign rsp_store_full = full_ff;

endmodule

`default_nettype wire

FILE: design/greedy_corner_spacing_filter.sv
// Top level of the greedy corner spacing filter: controller plus datapath.
//
// Corners of a frame arrive on the req_ channel strongest first, one beat per
// corner with its column, row and spacing range; req_start_of_frame empties
// the point store before that corner is tested. Each corner yields exactly one
// beat on the rsp_ channel: whether it was kept, its coordinates, the number of
// points kept so far and whether the per-frame limit has been reached.
// csr_wr_data sets the limit (zero means the whole store); write it only while
// no corner is in flight.
// One corner is worked on at a time. With points in the store, the request
// beat is followed by a check, a scan that reads the store RAM one point per
// cycle, a drain for the last registered read, and the result register; an
// empty or full store goes from the check straight to the result. The next
// request is taken the cycle after the result is registered.
// The result register frees the scan logic: a new corner may be taken while
// the previous result is stalled, but its own result waits until that beat
// leaves. Reset empties the store, clears the limit and drops rsp_valid; the
// store contents need no clearing.
`default_nettype none

module greedy_corner_spacing_filter
   import gcsf_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_start_of_frame,
   input  wire logic [COORD_BITS-1:0] req_corner_x,
   input  wire logic [COORD_BITS-1:0] req_corner_y,
   input  wire logic [RANGE_W-1:0]    req_spacing_range,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic [COORD_BITS-1:0]      rsp_kept_x,
   output logic [COORD_BITS-1:0]      rsp_kept_y,
   output logic [KEPT_CNT_W-1:0]      rsp_kept_count,
   output logic                       rsp_store_full,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_W-1:0]      csr_wr_data
);

   gcsf_cmd_type    cmd;
   gcsf_status_type status;

   gcsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gcsf_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_start_of_frame (req_start_of_frame),
      .req_corner_x       (req_corner_x),
      .req_corner_y       (req_corner_y),
      .req_spacing_range  (req_spacing_range),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_kept_x         (rsp_kept_x),
      .rsp_kept_y         (rsp_kept_y),
      .rsp_kept_count     (rsp_kept_count),
      .rsp_store_full     (rsp_store_full)
   );

endmodule

`default_nettype wire

FILE: design/gcsf_checker.sv
// Port-level checker for the greedy corner spacing filter and its bind.
`default_nettype none

module gcsf_checker
   import gcsf_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic                  rsp_accepted,
   input wire logic [COORD_BITS-1:0] rsp_kept_x,
   input wire logic [COORD_BITS-1:0] rsp_kept_y,
   input wire logic [KEPT_CNT_W-1:0] rsp_kept_count,
   input wire logic                  rsp_store_full
);

   // A stalled result beat stays offered.
   rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result beat keeps its payload.
   rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_accepted) && $stable(rsp_kept_x) &&
         $stable(rsp_kept_y) && $stable(rsp_kept_count) && $stable(rsp_store_full))
      else $error("rsp payload changed while stalled");

   // Corners are processed one at a time: a taken request closes the input.
   one_corner_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a corner is in flight");

   // Reset leaves no result beat behind.
   reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind greedy_corner_spacing_filter gcsf_checker #(
   .COORD_BITS (COORD_BITS)
) u_gcsf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accepted   (rsp_accepted),
   .rsp_kept_x     (rsp_kept_x),
   .rsp_kept_y     (rsp_kept_y),
   .rsp_kept_count (rsp_kept_count),
   .rsp_store_full (rsp_store_full)
);

`default_nettype wire
